>>> hw/rtl/acm_pkg.sv
// Shared types, widths and the square-root digit step for the accelerometer
// sample converter. No dependencies.
package acm_pkg;

   localparam int BYTE_W    = 8;
   localparam int DROP_BITS = 4;
   localparam int AXIS_W    = 12;
   localparam int PROD_W    = 2 * AXIS_W;
   // The largest square is 2048^2 = 2^22, so the squares need 23 bits.
   localparam int SQ_W      = 2 * AXIS_W - 1;
   // Three squares sum below 2^24.
   localparam int SUM_W     = SQ_W + 1;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int DIGITS_PER_STAGE = 2;
   localparam int SQRT_STAGES      = ROOT_W / DIGITS_PER_STAGE;
   localparam int TAG_W     = 3 * AXIS_W;
   localparam int REQ_W     = 6 * BYTE_W;
   localparam int RSP_W     = 4 * AXIS_W;
   localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'(3547);

   typedef logic signed [AXIS_W-1:0] axis_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SUM_W-1:0]  rad;
   } sqrt_state_type;

   // One binary digit (one root bit) of restoring square root: bring down two radicand bits
   // and try to subtract 4*root + 1.
   function automatic sqrt_state_type sqrt_digit(input sqrt_state_type cur);
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      sqrt_state_type   nxt;
      rem_sh = {cur.rem, cur.rad[SUM_W-1 -: 2]};
      trial  = (REM_W+2)'({cur.root, 2'b01});
      nxt.rad = {cur.rad[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         nxt.rem  = REM_W'(rem_sh - trial);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh[REM_W-1:0];
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

>>> hw/rtl/acm_isqrt.sv
// Pipelined floor integer square root, two result bits per stage, with a
// side-band tag that travels alongside. Depends on acm_pkg.
module acm_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [acm_pkg::SUM_W-1:0]     in_rad,
   input  logic [acm_pkg::TAG_W-1:0]     in_tag,
   output logic                          out_valid,
   output logic [acm_pkg::ROOT_W-1:0]    out_root,
   output logic [acm_pkg::TAG_W-1:0]     out_tag
);
   import acm_pkg::*;

   logic           valid_ff [SQRT_STAGES];
   sqrt_state_type st_ff    [SQRT_STAGES];
   sqrt_state_type st_in    [SQRT_STAGES];
   sqrt_state_type src      [SQRT_STAGES];
   logic [TAG_W-1:0] tag_ff [SQRT_STAGES];

   always_comb begin
      src[0].rem  = '0;
      src[0].root = '0;
      src[0].rad  = in_rad;
      for (int s = 1; s < SQRT_STAGES; s++) begin
         src[s] = st_ff[s-1];
      end
      for (int s = 0; s < SQRT_STAGES; s++) begin
         st_in[s] = src[s];
         for (int d = 0; d < DIGITS_PER_STAGE; d++) begin
            st_in[s] = sqrt_digit(st_in[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         for (int s = 0; s < SQRT_STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = st_ff[SQRT_STAGES-1].root;
   assign out_tag   = tag_ff[SQRT_STAGES-1];

endmodule

>>> hw/rtl/accel_sample_convert_magnitude.sv
// Top level of the accelerometer sample converter: byte unpacking, squaring,
// summing and the square-root pipeline. Depends on acm_pkg and acm_isqrt.
//
//   channel | direction | carries
//   req_    | in        | one raw sample: high and low byte per axis
//   rsp_    | out       | signed X, Y, Z counts and vector magnitude
//
// A sample is taken every cycle unless the output is held; the transfer loads
// the first of nine register stages (3 arithmetic
// stages plus 6 square-root stages, two root bits each).
// The last square-root stage is the output register.
// Reset clears only the valid bits; the data registers are not reset.
// When the output is held and not taken, the whole pipeline holds with it.
module accel_sample_convert_magnitude (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [7:0] x_high, [15:8] x_low, [23:16] y_high, [31:24] y_low,
   // [39:32] z_high, [47:40] z_low
   input  logic [acm_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [11:0] x_accel, [23:12] y_accel, [35:24] z_accel, [47:36] magnitude
   output logic [acm_pkg::RSP_W-1:0]  rsp_tdata
);
   import acm_pkg::*;

   logic en;

   // Stage 1: axis counts
   logic     cnt_valid_ff;
   axis_type x_ff, y_ff, z_ff;
   axis_type x_in, y_in, z_in;

   // Stage 2: squares
   logic              sq_valid_ff;
   logic [SQ_W-1:0]   xsq_ff, ysq_ff, zsq_ff;
   logic [PROD_W-1:0] xsq_in, ysq_in, zsq_in;
   logic [TAG_W-1:0]  sq_tag_ff;

   // Stage 3: sum
   logic              sum_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [TAG_W-1:0]  sum_tag_ff;

   logic              out_valid;
   logic [ROOT_W-1:0] out_root;
   logic [TAG_W-1:0]  out_tag;

   // Advance everything unless a finished result is waiting.
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      // Drop the low nibble of each low byte; the 12 bits left are two's complement.
      x_in = {req_tdata[0*BYTE_W +: BYTE_W], req_tdata[1*BYTE_W + DROP_BITS +: DROP_BITS]};
      y_in = {req_tdata[2*BYTE_W +: BYTE_W], req_tdata[3*BYTE_W + DROP_BITS +: DROP_BITS]};
      z_in = {req_tdata[4*BYTE_W +: BYTE_W], req_tdata[5*BYTE_W + DROP_BITS +: DROP_BITS]};
      xsq_in = PROD_W'(x_ff * x_ff);
      ysq_in = PROD_W'(y_ff * y_ff);
      zsq_in = PROD_W'(z_ff * z_ff);
      sum_in = SUM_W'(xsq_ff) + SUM_W'(ysq_ff) + SUM_W'(zsq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         cnt_valid_ff <= req_tvalid;
         sq_valid_ff  <= cnt_valid_ff;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         xsq_ff     <= xsq_in[SQ_W-1:0];
         ysq_ff     <= ysq_in[SQ_W-1:0];
         zsq_ff     <= zsq_in[SQ_W-1:0];
         sq_tag_ff  <= {z_ff, y_ff, x_ff};
         sum_ff     <= sum_in;
         sum_tag_ff <= sq_tag_ff;
      end
   end

   acm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sum_valid_ff),
      .in_rad    (sum_ff),
      .in_tag    (sum_tag_ff),
      .out_valid (out_valid),
      .out_root  (out_root),
      .out_tag   (out_tag)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {out_root, out_tag};

endmodule

>>> hw/rtl/acm_check.sv
// Port-level checks for the accelerometer sample converter, bound to the top
// level. Depends on acm_pkg.
module acm_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [acm_pkg::RSP_W-1:0]  rsp_tdata
);
   import acm_pkg::*;

   logic [ROOT_W-1:0] mag;
   axis_type          x_acc;
   logic [AXIS_W-1:0] x_abs;

   assign mag   = rsp_tdata[3*AXIS_W +: AXIS_W];
   assign x_acc = rsp_tdata[0 +: AXIS_W];
   assign x_abs = x_acc[AXIS_W-1] ? AXIS_W'(-x_acc) : x_acc;

   // A held result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With nothing waiting at the output the pipeline must take samples.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output");

   a_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mag <= MAG_MAX) && (x_abs == 12'h800 || mag >= x_abs))
      else $error("magnitude out of range");

endmodule

bind accel_sample_convert_magnitude acm_check u_acm_check (.*);
